[rtl/odm_pkg.sv]
// shared types and constants for the one-edit dictionary match block
`timescale 1ns / 1ps

package odm_pkg;

	localparam int CHAR_W = 8;
	localparam int NEAR_W = 7;
	localparam logic [NEAR_W-1:0] NEAR_MAX = 7'd127;

	localparam logic [1:0] MODE_DICT  = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN
	} odm_state_t;

	typedef struct packed {
		logic append;
		logic clear;
	} entry_ctl_t;

	typedef struct packed {
		logic start;
		logic issue;
	} cmp_ctl_t;

endpackage

[rtl/dictionary_one_edit_match.sv]
// top level: entry gathering, dictionary store and query scan sequencer
//
// channel  | signals                                  | transfer
// ---------+------------------------------------------+------------------------------
// command  | start, busy, mode, char_code, last_char  | edge with start high, busy low
// result   | result_strobe, accepted, exact_found,    | every edge with strobe high
//          | near_count, query_too_long,               |
//          | dictionary_full                           |
//
// a character, a clear, or a dropped word end is handled in the idle state
// a stored word end passes through the write state (one row write)
// a query end takes one row memory read per stored word, then the read and
// compare stages drain; an overlong query answers the next cycle
// reset clears counts, state and the dropped and strobe flags, not result fields;
// rows are only read below the word count
// the result is shown for one cycle and cannot be held off
`timescale 1ns / 1ps

module dictionary_one_edit_match #(
	parameter int MAX_WORDS = 64,
	parameter int MAX_CHARS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       result_strobe,
	output logic       accepted,
	output logic       exact_found,
	output logic [6:0] near_count,
	output logic       query_too_long,
	output logic       dictionary_full
);
	import odm_pkg::*;

	localparam int PW    = $clog2(MAX_CHARS + 1);
	localparam int CW    = $clog2(MAX_WORDS + 1);
	localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int ROW_W = MAX_CHARS * CHAR_W + PW;
	localparam int SW    = (CW > NEAR_W) ? CW : NEAR_W;

	odm_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          dropped_q, dropped_d;

	entry_ctl_t ectl;
	cmp_ctl_t   cctl;
	logic       we;
	logic       re;
	logic       res_load;
	logic       res_too_long;
	logic       ovf_next;

	logic [MAX_CHARS-1:0][CHAR_W-1:0] entry_chars;
	logic [PW-1:0]                    entry_pos;
	logic                             entry_ovf;
	logic [ROW_W-1:0]                 wdata;
	logic [ROW_W-1:0]                 rdata;
	logic [MAX_CHARS-1:0][CHAR_W-1:0] row_chars;
	logic [PW-1:0]                    row_len;
	logic                             exact;
	logic [CW-1:0]                    near;
	logic                             pending;
	logic [SW-1:0]                    near_ext;

	logic              strobe_q;
	logic              accepted_q;
	logic              exact_q;
	logic [NEAR_W-1:0] near_q;
	logic              too_long_q;
	logic              full_q;

	odm_entry_buf #(
		.MAX_CHARS(MAX_CHARS)
	) u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ectl),
		.char_code(char_code),
		.chars    (entry_chars),
		.pos      (entry_pos),
		.overflow (entry_ovf)
	);

	assign wdata = {entry_pos, entry_chars};

	odm_row_mem #(
		.DEPTH (MAX_WORDS),
		.WIDTH (ROW_W),
		.ADDR_W(AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	assign row_chars = rdata[MAX_CHARS*CHAR_W-1:0];
	assign row_len   = rdata[ROW_W-1 -: PW];

	odm_row_cmp #(
		.MAX_CHARS(MAX_CHARS),
		.MAX_WORDS(MAX_WORDS)
	) u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cctl),
		.row_chars  (row_chars),
		.row_len    (row_len),
		.entry_chars(entry_chars),
		.entry_pos  (entry_pos),
		.exact      (exact),
		.near       (near),
		.pending    (pending)
	);

	assign ovf_next = entry_ovf || (entry_pos == PW'(MAX_CHARS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			idx_q     <= idx_d;
			dropped_q <= dropped_d;
		end
	end

	// rows are written and read only in separate states, so no forwarding is needed
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		dropped_d    = dropped_q;
		ectl         = '0;
		cctl         = '0;
		we           = 1'b0;
		re           = 1'b0;
		res_load     = 1'b0;
		res_too_long = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_CLEAR: begin
							count_d    = '0;
							dropped_d  = 1'b0;
							ectl.clear = 1'b1;
						end
						MODE_DICT, MODE_QUERY: begin
							ectl.append = 1'b1;
							if (last_char) begin
								if (mode == MODE_DICT) begin
									if (!ovf_next && (count_q < CW'(MAX_WORDS))) begin
										state_d = ST_WRITE;
									end else begin
										ectl.clear = 1'b1;
										if (!ovf_next) begin
											dropped_d = 1'b1;
										end
									end
								end else if (ovf_next) begin
									ectl.clear   = 1'b1;
									res_load     = 1'b1;
									res_too_long = 1'b1;
								end else begin
									state_d    = ST_SCAN;
									idx_d      = '0;
									cctl.start = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WRITE: begin
				we         = 1'b1;
				count_d    = count_q + CW'(1);
				ectl.clear = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SCAN: begin
				if (idx_q < count_q) begin
					re         = 1'b1;
					cctl.issue = 1'b1;
					idx_d      = idx_q + CW'(1);
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pending) begin
					res_load   = 1'b1;
					ectl.clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign near_ext = SW'(near);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			too_long_q <= res_too_long;
			full_q     <= dropped_q;
			if (res_too_long) begin
				accepted_q <= 1'b0;
				exact_q    <= 1'b0;
				near_q     <= '0;
			end else begin
				accepted_q <= exact || (near == CW'(1));
				exact_q    <= exact;
				near_q     <= (near_ext > SW'(NEAR_MAX)) ? NEAR_MAX : near_ext[NEAR_W-1:0];
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign result_strobe   = strobe_q;
	assign accepted        = accepted_q;
	assign exact_found     = exact_q;
	assign near_count      = near_q;
	assign query_too_long  = too_long_q;
	assign dictionary_full = full_q;

endmodule

[rtl/odm_entry_buf.sv]
// entry buffer that gathers the characters of the current word or query
`timescale 1ns / 1ps

module odm_entry_buf #(
	parameter int MAX_CHARS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  odm_pkg::entry_ctl_t                       ctl,
	input  logic [7:0]                                char_code,
	output logic [MAX_CHARS-1:0][7:0]                 chars,
	output logic [$clog2(MAX_CHARS+1)-1:0]            pos,
	output logic                                      overflow
);
	import odm_pkg::*;

	localparam int PW = $clog2(MAX_CHARS + 1);
	localparam int IW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

	logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_q;
	logic [PW-1:0]                    pos_q;
	logic                             ovf_q;

	// clear wins over append: a dropped word end or an overlong query end is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.clear) begin
			chars_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.append) begin
			if (pos_q < PW'(MAX_CHARS)) begin
				chars_q[pos_q[IW-1:0]] <= char_code;
				pos_q <= pos_q + PW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign chars    = chars_q;
	assign pos      = pos_q;
	assign overflow = ovf_q;

endmodule

[rtl/odm_row_mem.sv]
// dictionary row memory, one write port and one registered read port
`timescale 1ns / 1ps

module odm_row_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 133,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	import odm_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/odm_row_cmp.sv]
// row compare stage and exact / near-miss accumulators
`timescale 1ns / 1ps

module odm_row_cmp #(
	parameter int MAX_CHARS = 16,
	parameter int MAX_WORDS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  odm_pkg::cmp_ctl_t                  ctl,
	input  logic [MAX_CHARS-1:0][7:0]          row_chars,
	input  logic [$clog2(MAX_CHARS+1)-1:0]     row_len,
	input  logic [MAX_CHARS-1:0][7:0]          entry_chars,
	input  logic [$clog2(MAX_CHARS+1)-1:0]     entry_pos,
	output logic                               exact,
	output logic [$clog2(MAX_WORDS+1)-1:0]     near,
	output logic                               pending
);
	import odm_pkg::*;

	localparam int NW = $clog2(MAX_WORDS + 1);

	logic                 vld_s1;
	logic                 vld_s2;
	logic                 zero_s2;
	logic                 one_s2;
	logic [MAX_CHARS-1:0] diff;
	logic                 len_eq;
	logic                 zero_diff;
	logic                 one_diff;
	logic                 exact_q;
	logic [NW-1:0]        near_q;

	// rows beyond their length hold zeros, as does the entry buffer
	always_comb begin
		for (int k = 0; k < MAX_CHARS; k++) begin
			diff[k] = (row_chars[k] != entry_chars[k]);
		end
	end

	assign len_eq    = (row_len == entry_pos);
	assign zero_diff = ~|diff;
	assign one_diff  = (|diff) && ((diff & (diff - MAX_CHARS'(1))) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			zero_s2 <= 1'b0;
			one_s2  <= 1'b0;
			exact_q <= 1'b0;
			near_q  <= '0;
		end else begin
			vld_s1  <= ctl.issue;
			vld_s2  <= vld_s1;
			zero_s2 <= vld_s1 && len_eq && zero_diff;
			one_s2  <= vld_s1 && len_eq && one_diff;
			if (ctl.start) begin
				exact_q <= 1'b0;
				near_q  <= '0;
			end else if (vld_s2) begin
				if (zero_s2) begin
					exact_q <= 1'b1;
				end
				if (one_s2) begin
					near_q <= near_q + NW'(1);
				end
			end
		end
	end

	assign exact   = exact_q;
	assign near    = near_q;
	assign pending = vld_s1 || vld_s2;

endmodule

[rtl/odm_checker.sv]
// port-level checks for the one-edit dictionary match block, bound to the top level
`timescale 1ns / 1ps

module odm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       last_char,
	input logic       result_strobe,
	input logic       accepted,
	input logic       exact_found,
	input logic [6:0] near_count,
	input logic       query_too_long
);
	import odm_pkg::*;

	logic query_end;
	logic other_xfer;

	assign query_end  = start && !busy && (mode == MODE_QUERY) && last_char;
	assign other_xfer = start && !busy && !((mode == MODE_QUERY) && last_char);

	a_accept_rule: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (accepted == (exact_found || (near_count == 7'd1))))
		else $error("accepted does not follow exact_found and near_count");

	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && query_too_long) |->
			(!accepted && !exact_found && (near_count == 7'd0)))
		else $error("overlong query answered with a match");

	a_query_answered: assert property (@(posedge clk) disable iff (!arst_n)
		query_end |=> (result_strobe || busy))
		else $error("query end neither answered nor scanned");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		other_xfer |=> !result_strobe)
		else $error("result without a query end");

endmodule

bind dictionary_one_edit_match odm_checker u_odm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.mode          (mode),
	.last_char     (last_char),
	.result_strobe (result_strobe),
	.accepted      (accepted),
	.exact_found   (exact_found),
	.near_count    (near_count),
	.query_too_long(query_too_long)
);
